@@ hw/rtl/square_matrix_multiply_core_macros.svh @@
// Assertion macros for the square matrix multiplier.
// Used by square_matrix_multiply_core; no other dependencies.
`ifndef SQUARE_MATRIX_MULTIPLY_CORE_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SQMM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SQMM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SQMM_ASSERT_IMP(label, ante, cons, msg)
`define SQMM_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

@@ hw/rtl/sqmm_pkg.sv @@
// Shared types and constants for the square matrix multiplier.
// No dependencies.
package sqmm_pkg;

    localparam int VALUE_W     = 32;
    localparam int ACC_W       = 64;
    localparam int FRAC_W      = 16;
    localparam int IDX_FIELD_W = 3;
    localparam int FIELD_REACH = 8;   // rows/cols reachable by a 3-bit index
    localparam int SIZE_W      = 4;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sd2147483648);

    // tag that travels with each multiply-accumulate term
    typedef struct packed {
        logic                   first;   // first term of a dot product
        logic                   dlast;   // final term of a dot product
        logic                   last;    // final term of the whole run
        logic [IDX_FIELD_W-1:0] row;
        logic [IDX_FIELD_W-1:0] col;
    } t_tag;

    function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [VALUE_W-1:0] res;
        if (x > SAT_MAX) begin
            res = VALUE_W'(SAT_MAX);
        end else if (x < SAT_MIN) begin
            res = VALUE_W'(SAT_MIN);
        end else begin
            res = x[VALUE_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/square_matrix_multiply_core.sv @@
// Square matrix multiplier core, signed Q16.16, one shared MAC unit.
// Depends on sqmm_pkg and square_matrix_multiply_core_macros.svh.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  request   | start / busy         | i_value, i_to_b, i_row, i_col, i_go
//  result    | o_valid (strobe)     | o_product, o_out_row, o_out_col, o_last
//  config    | i_size_we            | i_size_in_use
//
// A load request (go low) stores its element; busy stays low.
// A go request stores its element, then runs N*N*N terms through one
// multiplier and one accumulator, one term per cycle, passing through
// memory read, multiply, accumulate and saturate registers.
// Busy rises after a go request is taken and drops in the cycle
// that strobes the last product; results cannot be held off.
// Reset (synchronous, i_rst_n low) clears control and sets size to 8; the
// A and B stores are not cleared and must be loaded before use.
`include "square_matrix_multiply_core_macros.svh"

module square_matrix_multiply_core
    import sqmm_pkg::*;
#(
    parameter int MAX_SIZE = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      start,
    output logic                      busy,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_to_b,
    input  logic [IDX_FIELD_W-1:0]    i_row,
    input  logic [IDX_FIELD_W-1:0]    i_col,
    input  logic                      i_go,
    // config
    input  logic                      i_size_we,
    input  logic [SIZE_W-1:0]         i_size_in_use,
    // result channel
    output logic                      o_valid,
    output logic signed [VALUE_W-1:0] o_product,
    output logic [IDX_FIELD_W-1:0]    o_out_row,
    output logic [IDX_FIELD_W-1:0]    o_out_col,
    output logic                      o_last
);

    localparam int SIZE_LIMIT = (MAX_SIZE < FIELD_REACH) ? MAX_SIZE : FIELD_REACH;
    localparam int DEPTH      = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(SIZE_LIMIT);

    // ---------------- configuration ----------------
    logic [SIZE_W-1:0] r_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_W'(8);
        end else if (i_size_we) begin
            r_size <= i_size_in_use;
        end
    end

    // active size: zero acts as one, large values clip to the limit
    logic [SIZE_W-1:0] w_n;
    logic [CNT_W-1:0]  w_n_m1;

    always_comb begin
        if (r_size == '0) begin
            w_n = SIZE_W'(1);
        end else if (r_size > SIZE_W'(SIZE_LIMIT)) begin
            w_n = SIZE_W'(SIZE_LIMIT);
        end else begin
            w_n = r_size;
        end
        w_n_m1 = CNT_W'(w_n - SIZE_W'(1));
    end

    // ---------------- request acceptance ----------------
    logic w_accept;
    logic w_in_range;
    logic w_we_a;
    logic w_we_b;
    logic [ADDR_W-1:0] w_waddr;

    assign w_accept   = start && !busy;
    assign w_in_range = ({1'b0, i_row} < w_n) && ({1'b0, i_col} < w_n);
    assign w_we_a     = w_accept && w_in_range && !i_to_b;
    assign w_we_b     = w_accept && w_in_range &&  i_to_b;
    assign w_waddr    = ADDR_W'(ADDR_W'(i_row) * ADDR_W'(MAX_SIZE)) + ADDR_W'(i_col);

    // ---------------- sequencer: r, c, k counters ----------------
    logic             r_run;
    logic [CNT_W-1:0] r_r;
    logic [CNT_W-1:0] r_c;
    logic [CNT_W-1:0] r_k;
    logic             w_k_end;
    logic             w_c_end;
    logic             w_r_end;

    assign w_k_end = (r_k == w_n_m1);
    assign w_c_end = (r_c == w_n_m1);
    assign w_r_end = (r_r == w_n_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_r   <= '0;
            r_c   <= '0;
            r_k   <= '0;
        end else if (w_accept && i_go) begin
            r_run <= 1'b1;
            r_r   <= '0;
            r_c   <= '0;
            r_k   <= '0;
        end else if (r_run) begin
            if (!w_k_end) begin
                r_k <= r_k + CNT_W'(1);
            end else begin
                r_k <= '0;
                if (!w_c_end) begin
                    r_c <= r_c + CNT_W'(1);
                end else begin
                    r_c <= '0;
                    if (!w_r_end) begin
                        r_r <= r_r + CNT_W'(1);
                    end else begin
                        r_run <= 1'b0;
                    end
                end
            end
        end
    end

    // term tag for the issue cycle
    t_tag w_tag0;
    logic [ADDR_W-1:0] w_raddr_a;
    logic [ADDR_W-1:0] w_raddr_b;

    always_comb begin
        w_tag0.first = (r_k == '0);
        w_tag0.dlast = w_k_end;
        w_tag0.last  = w_k_end && w_c_end && w_r_end;
        w_tag0.row   = IDX_FIELD_W'(r_r);
        w_tag0.col   = IDX_FIELD_W'(r_c);
    end

    // A[r][k] and B[k][c]
    assign w_raddr_a = ADDR_W'(ADDR_W'(r_r) * ADDR_W'(MAX_SIZE)) + ADDR_W'(r_k);
    assign w_raddr_b = ADDR_W'(ADDR_W'(r_k) * ADDR_W'(MAX_SIZE)) + ADDR_W'(r_c);

    // ---------------- operand stores ----------------
    logic signed [VALUE_W-1:0] store_a [DEPTH];
    logic signed [VALUE_W-1:0] store_b [DEPTH];
    logic signed [VALUE_W-1:0] r_a_q;
    logic signed [VALUE_W-1:0] r_b_q;

    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            store_a[w_waddr] <= i_value;
        end
        r_a_q <= store_a[w_raddr_a];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_b) begin
            store_b[w_waddr] <= i_value;
        end
        r_b_q <= store_b[w_raddr_b];
    end

    // ---------------- MAC pipeline ----------------
    // stage 1: operands read, stage 2: product, stage 3: accumulator
    logic r_v1, r_v2, r_v3;
    t_tag r_t1, r_t2, r_t3;
    logic signed [ACC_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] w_term;

    // dropping 16 fraction bits rounds toward minus infinity
    assign w_term = r_prod >>> FRAC_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= r_run;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1   <= w_tag0;
        r_t2   <= r_t1;
        r_prod <= ACC_W'(r_a_q) * ACC_W'(r_b_q);
        if (r_v2) begin
            r_t3  <= r_t2;
            r_acc <= (r_t2.first ? '0 : r_acc) + w_term;
        end
    end

    // ---------------- saturation and result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v3 && r_t3.dlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && r_t3.dlast) begin
            o_product <= sat32(r_acc);
            o_out_row <= r_t3.row;
            o_out_col <= r_t3.col;
            o_last    <= r_t3.last;
        end
    end

    assign busy = r_run || r_v1 || r_v2 || r_v3;

    // ---------------- checks ----------------
    `SQMM_ASSERT_NXT(a_go_starts_run, w_accept && i_go, busy, "go request did not start a run")
    `SQMM_ASSERT_IMP(a_result_in_run, o_valid, $past(r_v3), "result strobe without a finished term")
    `SQMM_ASSERT_IMP(a_last_on_diag, o_valid && o_last, o_out_row == o_out_col, "last flag off corner")
    `SQMM_ASSERT_IMP(a_cnt_bound, r_run, (r_k <= w_n_m1) && (r_c <= w_n_m1) && (r_r <= w_n_m1), "counter past size")

endmodule

@@ bench/tb_square_matrix_multiply_core.sv @@
// Self-checking bench for square_matrix_multiply_core: loads A/B, runs multiplies, checks P.
// Depends on sqmm_pkg and the core RTL only; needs no files or arguments.
// Predicts every product element and compares each strobed result in order.
module tb_square_matrix_multiply_core;
    import sqmm_pkg::*;

    // Store geometry of the instance (default MAX_SIZE)
    localparam int DIM = 8;
    // Stop generating once about this many requests that do something are queued
    localparam int ITEM_TARGET = 330;
    // Idle cycles before a size write and after the last result
    localparam int SETTLE_CYC = 12;
    localparam int TAIL_CYC = 600;     // well above the length of a run for N = 8
    localparam longint PROD_MAX = 64'sd2147483647;
    localparam longint PROD_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      to_b;
        logic [IDX_FIELD_W-1:0]    row;
        logic [IDX_FIELD_W-1:0]    col;
        logic                      go;
        bit                        hold;   // wait for all products before sending
    } t_elem_req;

    typedef struct {
        logic signed [VALUE_W-1:0] product;
        logic [IDX_FIELD_W-1:0]    row;
        logic [IDX_FIELD_W-1:0]    col;
        logic                      last;
    } t_prod;

    // DUT connections, every input driven to a known value from time zero
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      i_to_b = 1'b0;
    logic [IDX_FIELD_W-1:0]    i_row = '0;
    logic [IDX_FIELD_W-1:0]    i_col = '0;
    logic                      i_go = 1'b0;
    logic                      i_size_we = 1'b0;
    logic [SIZE_W-1:0]         i_size_in_use = 4'd8;
    logic                      o_valid;
    logic signed [VALUE_W-1:0] o_product;
    logic [IDX_FIELD_W-1:0]    o_out_row;
    logic [IDX_FIELD_W-1:0]    o_out_col;
    logic                      o_last;

    square_matrix_multiply_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_to_b        (i_to_b),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_go          (i_go),
        .i_size_we     (i_size_we),
        .i_size_in_use (i_size_in_use),
        .o_valid       (o_valid),
        .o_product     (o_product),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_last        (o_last)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of both stores and the size register
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] mat_a [DIM*DIM];
    logic signed [VALUE_W-1:0] mat_b [DIM*DIM];
    logic [SIZE_W-1:0]         size_cfg = 4'd8;   // reset value
    t_prod                     expected_products[$];

    // Request stream and bookkeeping
    t_elem_req pending_elements[$];
    t_elem_req cur_req;
    bit        in_flight = 1'b0;   // a request is on the port, not yet taken
    bit        calm = 1'b0;        // closing stretch: no sender gaps
    int        gap_left = 0;
    int        err_cnt = 0;
    int        reqs_taken = 0;
    int        runs_done = 0;
    int        products_seen = 0;
    int        size_writes = 0;

    // Generator view: which entries hold data, so no unwritten entry is read
    bit        loaded_a [DIM*DIM];
    bit        loaded_b [DIM*DIM];
    int        gen_n = DIM;
    int        items_gen = 0;

    // Size 0 behaves as 1, anything past the store reach clamps to 8
    function automatic int active_dim(logic [SIZE_W-1:0] cfg);
        int n;
        n = cfg;
        if (n == 0) n = 1;
        if (n > DIM) n = DIM;
        return n;
    endfunction

    // One P element: Q32.32 terms floored to Q48.16, exact 64-bit sum, saturate
    function automatic logic signed [VALUE_W-1:0] dot_product_q16(int r, int c, int n);
        longint acc;
        longint term;
        int     k;
        acc = 0;
        for (k = 0; k < n; k++) begin
            term = longint'(mat_a[r*DIM+k]) * longint'(mat_b[k*DIM+c]);
            acc += term >>> FRAC_W;   // arithmetic shift == floor
        end
        if (acc > PROD_MAX) return 32'h7FFF_FFFF;
        if (acc < PROD_MIN) return 32'h8000_0000;
        return acc[VALUE_W-1:0];
    endfunction

    // Store the element if it lands inside the matrix, then on go queue
    // every product element in row-major order
    function automatic void apply_element(t_elem_req rq);
        int    n;
        int    r;
        int    c;
        t_prod p;
        n = active_dim(size_cfg);
        if (rq.row < n && rq.col < n) begin
            if (rq.to_b) mat_b[rq.row*DIM+rq.col] = rq.value;
            else         mat_a[rq.row*DIM+rq.col] = rq.value;
        end
        if (rq.go) begin
            runs_done++;
            for (r = 0; r < n; r++) begin
                for (c = 0; c < n; c++) begin
                    p.product = dot_product_q16(r, c, n);
                    p.row     = IDX_FIELD_W'(r);
                    p.col     = IDX_FIELD_W'(c);
                    p.last    = (r == n - 1) && (c == n - 1);
                    expected_products.push_back(p);
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued requests at the falling edge, holds each
    // one until the monitor sees it taken, inserts random gap bursts
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic nxt;
        nxt = start;
        if (!i_rst_n) begin
            nxt = 1'b0;
        end else if (!in_flight) begin
            nxt = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_elements.size() != 0 &&
                         !(pending_elements[0].hold && expected_products.size() != 0)) begin
                cur_req = pending_elements.pop_front();
                i_value <= cur_req.value;
                i_to_b  <= cur_req.to_b;
                i_row   <= cur_req.row;
                i_col   <= cur_req.col;
                i_go    <= cur_req.go;
                nxt = 1'b1;
                in_flight = 1'b1;
                // gap after this request is taken
                if (!calm && $urandom_range(0, 99) < 18) gap_left = $urandom_range(1, 13);
            end
        end
        start <= nxt;
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge, note an accepted request (start high,
    // busy low) and check any strobed product against the oldest one due
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_prod want;
        if (i_rst_n) begin
            if (start && !busy) begin
                in_flight = 1'b0;
                reqs_taken++;
                apply_element(cur_req);
            end
            if (o_valid) begin
                products_seen++;
                if (expected_products.size() == 0) begin
                    err_cnt++;
                    $error("product with none due: row %0d col %0d value %0d",
                           o_out_row, o_out_col, o_product);
                end else begin
                    want = expected_products.pop_front();
                    if (o_product !== want.product) begin
                        err_cnt++;
                        $error("product: expected %0d, got %0d", want.product, o_product);
                    end
                    if (o_out_row !== want.row) begin
                        err_cnt++;
                        $error("out_row: expected %0d, got %0d", want.row, o_out_row);
                    end
                    if (o_out_col !== want.col) begin
                        err_cnt++;
                        $error("out_col: expected %0d, got %0d", want.col, o_out_col);
                    end
                    if (o_last !== want.last) begin
                        err_cnt++;
                        $error("last: expected %0d, got %0d", want.last, o_last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    // Mostly small Q16.16 values (|x| <= 16) so sums stay in range; some
    // full-range and extreme words to hit saturation and every data bit
    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom();
            4:       return -32'sd1;
            default: return $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
        endcase
    endfunction

    task automatic queue_elem(logic signed [VALUE_W-1:0] value, logic to_b, int row, int col,
                              logic go, bit hold);
        t_elem_req rq;
        rq.value = value;
        rq.to_b  = to_b;
        rq.row   = IDX_FIELD_W'(row);
        rq.col   = IDX_FIELD_W'(col);
        rq.go    = go;
        rq.hold  = hold;
        if (row < gen_n && col < gen_n) begin
            if (to_b) loaded_b[row*DIM+col] = 1'b1;
            else      loaded_a[row*DIM+col] = 1'b1;
        end
        // requests that fall outside and carry no go are ignored, not counted
        if (go || (row < gen_n && col < gen_n)) items_gen++;
        pending_elements.push_back(rq);
    endtask

    // A go request; any entry inside the matrix not yet holding data is
    // loaded first, since the multiply reads every entry within N
    task automatic queue_go(logic signed [VALUE_W-1:0] value, logic to_b, int row, int col,
                            bit hold);
        int k;
        if (row < gen_n && col < gen_n) begin
            if (to_b) loaded_b[row*DIM+col] = 1'b1;
            else      loaded_a[row*DIM+col] = 1'b1;
        end
        for (k = 0; k < DIM*DIM; k++) begin
            if (k / DIM < gen_n && k % DIM < gen_n) begin
                if (!loaded_a[k]) queue_elem(rand_value(), 1'b0, k / DIM, k % DIM, 1'b0, 1'b0);
                if (!loaded_b[k]) queue_elem(rand_value(), 1'b1, k / DIM, k % DIM, 1'b0, 1'b0);
            end
        end
        queue_elem(value, to_b, row, col, 1'b1, hold);
    endtask

    // Mostly a load sequence ending in go; the rest stray loads anywhere
    // (outside the matrix too) or a go whose own element may miss
    task automatic queue_sequence();
        int kind;
        int nl;
        int i;
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
            nl = $urandom_range(0, gen_n * gen_n);
            // keep the total near the target
            if (nl > ITEM_TARGET - items_gen) nl = ITEM_TARGET - items_gen;
            if (nl < 0) nl = 0;
            for (i = 0; i < nl; i++) begin
                queue_elem(rand_value(), 1'($urandom_range(0, 1)),
                           $urandom_range(0, gen_n - 1), $urandom_range(0, gen_n - 1),
                           1'b0, 1'b0);
            end
            queue_go(rand_value(), 1'($urandom_range(0, 1)),
                     $urandom_range(0, gen_n - 1), $urandom_range(0, gen_n - 1),
                     $urandom_range(0, 9) == 0);
        end else if (kind < 93) begin
            repeat (3) begin
                queue_elem(rand_value(), 1'($urandom_range(0, 1)),
                           $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1), 1'b0, 1'b0);
            end
        end else begin
            queue_go(rand_value(), 1'($urandom_range(0, 1)),
                     $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1), 1'b0);
        end
    endtask

    // Wait until no request is queued or on the port and no product is due
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_elements.size() != 0 || in_flight || expected_products.size() != 0);
    endtask

    // Size writes only with the block idle; a plain load leaves no product
    // behind, so let it retire first
    task automatic write_size(logic [SIZE_W-1:0] cfg);
        wait_idle();
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_size_in_use <= cfg;
        i_size_we     <= 1'b1;
        size_cfg = cfg;
        gen_n = active_dim(cfg);
        size_writes++;
        @(negedge i_clk);
        i_size_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed cases, random phases, drain, verdict
    // ------------------------------------------------------------------
    initial begin
        int                phase;
        logic [SIZE_W-1:0] cfg;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Size zero acts as 1x1: saturation both ways, floor of a tiny
        // negative product, and a go whose element lies outside
        write_size(4'd0);
        queue_elem(32'h7FFF_FFFF, 1'b0, 0, 0, 1'b0, 1'b0);
        queue_go(32'h7FFF_FFFF, 1'b1, 0, 0, 1'b0);        // max*max -> clamps high
        queue_elem(32'h8000_0000, 1'b0, 0, 0, 1'b0, 1'b0);
        queue_go(32'h0000_0000, 1'b1, 7, 7, 1'b0);        // not stored; min*max clamps low
        queue_go(32'h8000_0000, 1'b1, 0, 0, 1'b1);        // min*min clamps high
        queue_elem(32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0, 1'b0);
        queue_go(32'h0000_0001, 1'b1, 0, 0, 1'b0);        // -1 LSB * 1 LSB floors to -1

        // 2x2 with mixed signs, stray loads outside, then a held go
        write_size(4'd2);
        queue_elem(32'h0001_8000, 1'b0, 0, 0, 1'b0, 1'b0); //  1.5
        queue_elem(32'hFFFD_C000, 1'b0, 0, 1, 1'b0, 1'b0); // -2.25
        queue_elem(32'h0000_8000, 1'b0, 1, 0, 1'b0, 1'b0); //  0.5
        queue_elem(32'h0003_0000, 1'b0, 1, 1, 1'b0, 1'b0); //  3.0
        queue_elem(32'hFFFF_0000, 1'b1, 0, 0, 1'b0, 1'b0); // -1.0
        queue_elem(32'h0002_4000, 1'b1, 0, 1, 1'b0, 1'b0); //  2.25
        queue_elem(32'h1234_5678, 1'b1, 2, 0, 1'b0, 1'b0); // outside, dropped
        queue_elem(32'hDEAD_BEEF, 1'b1, 7, 7, 1'b0, 1'b0); // outside, dropped
        queue_elem(32'h0000_0001, 1'b1, 1, 0, 1'b0, 1'b0);
        queue_go(32'hFFFF_FFFF, 1'b1, 1, 1, 1'b0);
        queue_go(32'h7FFF_FFFF, 1'b0, 5, 6, 1'b1);         // sent only once P is drained

        // Random phases: a new size each, extremes first
        phase = 0;
        while (items_gen < ITEM_TARGET) begin
            case (phase)
                0:       cfg = 4'd15;   // clamps to 8; loads the full stores
                1:       cfg = 4'd1;
                2:       cfg = 4'd8;
                3:       cfg = 4'd9;
                4:       cfg = 4'd0;
                default: cfg = SIZE_W'($urandom_range(0, 15));
            endcase
            write_size(cfg);
            repeat ($urandom_range(1, 4)) if (items_gen < ITEM_TARGET) queue_sequence();
            if (items_gen > ITEM_TARGET * 85 / 100) calm = 1'b1;
            phase++;
        end
        calm = 1'b1;

        wait_idle();
        repeat (TAIL_CYC) @(negedge i_clk);

        $display("Run covered %0d requests, %0d multiplies, %0d size writes",
                 reqs_taken, runs_done, size_writes);
        $display("Sizes 0, 1, 8, 9, 15 included; checked %0d product elements, %0d mismatches",
                 products_seen, err_cnt);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest legal run
    initial begin
        #30_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
